@@ design/pfd_pkg.sv @@
// shared types and constants for the packet fifo with drop counters
// no dependencies; imported by the top level and the testbench
`timescale 1ns / 1ps
`default_nettype none

package pfd_pkg;

   // width of the max packet length register and its value after reset
   localparam int unsigned CFG_W = 12;
   localparam logic [CFG_W-1:0] MAX_LEN_RESET = 12'd1124;

   // width of the wrapping packet counters
   localparam int unsigned CNT_W = 32;

   // result status codes
   typedef enum logic [2:0] {
      ST_TAKEN     = 3'd0,
      ST_QUEUED    = 3'd1,
      ST_DROP_FULL = 3'd2,
      ST_DROP_LONG = 3'd3,
      ST_READ      = 3'd4,
      ST_EMPTY     = 3'd5
   } status_type;

endpackage : pfd_pkg

`default_nettype wire

@@ design/packet_fifo_with_drop_counters.sv @@
// top level of the circular packet fifo with full-drop and length-drop handling
// depends on pfd_pkg and pfd_ram
`timescale 1ns / 1ps
`default_nettype none

//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  req_    | in        | req_valid/stall    | mode, data_byte, byte_last
//  rsp_    | out       | rsp_valid/stall    | status, out_byte, out_last, queued_packets,
//          |           |                    | received_total, sent_total, dropped_total
//  csr_    | in        | csr_valid/ready    | max_packet_len (ready is always high)
//
//  per item, the transfer cycle issues the byte and length ram reads; once the output
//  register is free, the registered read data is used, the queue state updated and written back
//  the ram access is the limit: one read then one write per item, never overlapping
//  a result waits in the output register; a new item is taken while it waits, and is
//  finished only once that register is free
//  synchronous reset clears pointers, flags and counters; ram contents are left alone

module packet_fifo_with_drop_counters
   import pfd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 64,
   parameter int unsigned SLOT_BYTES  = 2048
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // item input
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_mode,
   input  wire logic [7:0]                        req_data_byte,
   input  wire logic                              req_byte_last,
   // result output
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [2:0]                        rsp_status,
   output logic      [7:0]                        rsp_out_byte,
   output logic                                   rsp_out_last,
   output logic      [$clog2(QUEUE_DEPTH+1)-1:0]  rsp_queued_packets,
   output logic      [CNT_W-1:0]                  rsp_received_total,
   output logic      [CNT_W-1:0]                  rsp_sent_total,
   output logic      [CNT_W-1:0]                  rsp_dropped_total,
   // register write
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [CFG_W-1:0]                  csr_max_packet_len
);

   // slot index, packet count, byte offset within a slot, stored length
   localparam int unsigned QW  = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SBW = $clog2(SLOT_BYTES);
   localparam int unsigned OW  = $clog2(SLOT_BYTES + 1);
   // common width for the limit compare
   localparam int unsigned LW  = (OW > CFG_W) ? OW : CFG_W;
   // byte store: each slot gets a power of two span so the address is a concatenation
   localparam int unsigned BYTE_DEPTH = QUEUE_DEPTH * (2 ** SBW);

   localparam logic [QW-1:0] LAST_SLOT  = QW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
   localparam logic [LW-1:0] SLOT_LIMIT = LW'(SLOT_BYTES);
   localparam logic [SBW-1:0] LAST_OFF  = SBW'(SLOT_BYTES - 1);

   // item being worked on
   logic             busy_ff, busy_in;
   logic             mode_ff;
   logic [7:0]       byte_ff;
   logic             last_ff;

   // queue state
   logic [QW-1:0]    head_ff, head_in;
   logic [QW-1:0]    tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [OW-1:0]    wr_off_ff, wr_off_in;
   logic [SBW-1:0]   rd_off_ff, rd_off_in;
   logic             drop_full_ff, drop_full_in;
   logic             too_long_ff, too_long_in;
   logic [CNT_W-1:0] recv_ff, recv_in;
   logic [CNT_W-1:0] sent_ff, sent_in;
   logic [CNT_W-1:0] drop_ff, drop_in;
   logic [CFG_W-1:0] max_len_ff, max_len_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_last_ff, out_last_in;

   // ram side
   logic             accept;
   logic             done;
   logic             byte_we;
   logic             len_we;
   logic [7:0]       rd_byte;
   logic [OW-1:0]    rd_len;
   logic [LW-1:0]    cfg_ext;
   logic [LW-1:0]    limit;
   logic [OW-1:0]    rd_next;

   // handshakes
   assign accept    = req_valid & ~busy_ff;
   assign req_stall = busy_ff;
   // finish once the output register is free or being emptied this cycle
   assign done      = busy_ff & (~rsp_valid_ff | ~rsp_stall);
   assign csr_ready = 1'b1;

   // limit in force is the smaller of the register and the slot size
   assign cfg_ext = LW'(max_len_ff);
   assign limit   = (cfg_ext < SLOT_LIMIT) ? cfg_ext : SLOT_LIMIT;
   assign rd_next = OW'(rd_off_ff) + OW'(1);

   // packet bytes, addressed by {slot, offset}
   pfd_ram #(
      .WIDTH (8),
      .DEPTH (BYTE_DEPTH)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_we),
      .wr_addr ({tail_ff, wr_off_ff[SBW-1:0]}),
      .wr_data (byte_ff),
      .rd_en   (accept),
      .rd_addr ({head_ff, rd_off_ff}),
      .rd_data (rd_byte)
   );

   // committed packet lengths, one per slot
   pfd_ram #(
      .WIDTH (OW),
      .DEPTH (QUEUE_DEPTH)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (tail_ff),
      .wr_data (wr_off_ff + OW'(1)),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (rd_len)
   );

   // item processing: push or read, evaluated once the output register is free after the transfer
   always_comb begin
      busy_in      = busy_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      wr_off_in    = wr_off_ff;
      rd_off_in    = rd_off_ff;
      drop_full_in = drop_full_ff;
      too_long_in  = too_long_ff;
      recv_in      = recv_ff;
      sent_in      = sent_ff;
      drop_in      = drop_ff;
      max_len_in   = max_len_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      status_in    = status_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      byte_we      = 1'b0;
      len_we       = 1'b0;

      if (csr_valid) begin
         max_len_in = csr_max_packet_len;
      end

      if (accept) begin
         busy_in = 1'b1;
      end

      if (done) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         out_byte_in  = 8'd0;
         out_last_in  = 1'b0;
         if (!mode_ff) begin
            // push one byte
            if (wr_off_ff == OW'(0) && !drop_full_ff && !too_long_ff &&
                count_ff >= FULL_COUNT) begin
               // queue full at first byte: count once, skip the rest of the packet
               drop_in      = drop_ff + CNT_W'(1);
               drop_full_in = ~last_ff;
               status_in    = ST_DROP_FULL;
            end else if (drop_full_ff) begin
               if (last_ff) begin
                  drop_full_in = 1'b0;
               end
               status_in = ST_DROP_FULL;
            end else if (too_long_ff || LW'(wr_off_ff) >= limit) begin
               // sticky until the last byte of the packet
               status_in   = ST_DROP_LONG;
               too_long_in = ~last_ff;
               if (last_ff) begin
                  wr_off_in = '0;
               end
            end else begin
               byte_we = 1'b1;
               if (!last_ff) begin
                  wr_off_in = wr_off_ff + OW'(1);
                  status_in = ST_TAKEN;
               end else begin
                  // commit the packet
                  len_we    = 1'b1;
                  wr_off_in = '0;
                  tail_in   = (tail_ff == LAST_SLOT) ? '0 : tail_ff + QW'(1);
                  count_in  = count_ff + CW'(1);
                  recv_in   = recv_ff + CNT_W'(1);
                  status_in = ST_QUEUED;
               end
            end
         end else begin
            // read one byte of the head packet
            if (count_ff == CW'(0)) begin
               status_in = ST_EMPTY;
            end else begin
               status_in   = ST_READ;
               out_byte_in = rd_byte;
               if (rd_next >= rd_len || rd_off_ff == LAST_OFF) begin
                  out_last_in = 1'b1;
                  rd_off_in   = '0;
                  head_in     = (head_ff == LAST_SLOT) ? '0 : head_ff + QW'(1);
                  count_in    = count_ff - CW'(1);
                  sent_in     = sent_ff + CNT_W'(1);
               end else begin
                  rd_off_in = rd_off_ff + SBW'(1);
               end
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         wr_off_ff    <= '0;
         rd_off_ff    <= '0;
         drop_full_ff <= 1'b0;
         too_long_ff  <= 1'b0;
         recv_ff      <= '0;
         sent_ff      <= '0;
         drop_ff      <= '0;
         max_len_ff   <= MAX_LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         wr_off_ff    <= wr_off_in;
         rd_off_ff    <= rd_off_in;
         drop_full_ff <= drop_full_in;
         too_long_ff  <= too_long_in;
         recv_ff      <= recv_in;
         sent_ff      <= sent_in;
         drop_ff      <= drop_in;
         max_len_ff   <= max_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         byte_ff <= req_data_byte;
         last_ff <= req_byte_last;
      end
      status_ff   <= status_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   // state only moves when a result is loaded, so the totals are read straight
   // from the state registers while the result waits
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_out_last       = out_last_ff;
   assign rsp_queued_packets = count_ff;
   assign rsp_received_total = recv_ff;
   assign rsp_sent_total     = sent_ff;
   assign rsp_dropped_total  = drop_ff;

endmodule : packet_fifo_with_drop_counters

`default_nettype wire

@@ design/pfd_ram.sv @@
// generic simple dual port ram: one write port, one registered read port
// standalone, no package needed
`timescale 1ns / 1ps
`default_nettype none

module pfd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : pfd_ram

`default_nettype wire

@@ sim/tb_packet_fifo_with_drop_counters.sv @@
// self-checking testbench for packet_fifo_with_drop_counters: a checker class keeps a
// shadow of the packet queue and compares every result transfer, plain tasks drive traffic
// depends on pfd_pkg and the design top level
`timescale 1ns / 1ps

import pfd_pkg::*;

localparam logic MODE_PUSH = 1'b0;
localparam logic MODE_READ = 1'b1;

typedef struct packed {
   status_type  status;
   logic [7:0]  out_byte;
   logic        out_last;
   logic [6:0]  queued;
   logic [31:0] received;
   logic [31:0] sent;
   logic [31:0] dropped;
} pkt_result_type;

class packet_queue_checker;
   localparam int unsigned DEPTH      = 64;
   localparam int unsigned SLOT       = 2048;

   logic [7:0]     slot_mem [DEPTH*SLOT];
   logic [11:0]    slot_len [DEPTH];
   logic [5:0]     head_slot;
   logic [5:0]     tail_slot;
   logic [6:0]     held;
   logic [11:0]    wr_off;
   logic [11:0]    rd_off;
   bit             drop_run;
   bit             long_run;
   logic [31:0]    recv_total;
   logic [31:0]    sent_total;
   logic [31:0]    drop_total;
   logic [CFG_W-1:0] max_len;
   pkt_result_type pending_results [$];
   int unsigned    failures;

   function new();
      head_slot  = '0;
      tail_slot  = '0;
      held       = '0;
      wr_off     = '0;
      rd_off     = '0;
      drop_run   = 1'b0;
      long_run   = 1'b0;
      recv_total = '0;
      sent_total = '0;
      drop_total = '0;
      max_len    = MAX_LEN_RESET;
      failures   = 0;
   endfunction

   function void set_limit(logic [CFG_W-1:0] value);
      max_len = value;
   endfunction

   function status_type push_byte(logic [7:0] data, logic last);
      int unsigned limit;
      int unsigned idx;
      limit = (32'(max_len) < SLOT) ? 32'(max_len) : SLOT;
      // full check only at the first byte of a packet
      if (wr_off == 0 && !drop_run && !long_run && held >= DEPTH) begin
         drop_total++;
         drop_run = !last;
         return ST_DROP_FULL;
      end
      if (drop_run) begin
         if (last) drop_run = 1'b0;
         return ST_DROP_FULL;
      end
      if (!long_run && wr_off >= limit) long_run = 1'b1;
      if (long_run) begin
         if (last) begin
            long_run = 1'b0;
            wr_off   = '0;
         end
         return ST_DROP_LONG;
      end
      idx = int'(tail_slot) * SLOT + int'(wr_off);
      slot_mem[idx] = data;
      wr_off++;
      if (!last) return ST_TAKEN;
      slot_len[tail_slot] = wr_off;
      wr_off = '0;
      tail_slot++;
      held++;
      recv_total++;
      return ST_QUEUED;
   endfunction

   function status_type read_byte(output logic [7:0] data, output logic fin);
      int unsigned idx;
      data = '0;
      fin  = 1'b0;
      if (held == 0) return ST_EMPTY;
      idx  = int'(head_slot) * SLOT + int'(rd_off);
      data = slot_mem[idx];
      if (rd_off + 32'd1 >= slot_len[head_slot] || rd_off + 32'd1 >= SLOT) begin
         fin    = 1'b1;
         rd_off = '0;
         head_slot++;
         held--;
         sent_total++;
      end else begin
         rd_off++;
      end
      return ST_READ;
   endfunction

   // called at the edge an input item is transferred
   function void take_item(logic mode, logic [7:0] data, logic last);
      pkt_result_type want;
      logic [7:0]     rd_data;
      logic           rd_fin;
      want = '0;
      if (mode == MODE_READ) begin
         want.status   = read_byte(rd_data, rd_fin);
         want.out_byte = rd_data;
         want.out_last = rd_fin;
      end else begin
         want.status = push_byte(data, last);
      end
      want.queued   = held;
      want.received = recv_total;
      want.sent     = sent_total;
      want.dropped  = drop_total;
      pending_results.push_back(want);
   endfunction

   function int unsigned pending();
      return pending_results.size();
   endfunction

   function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   function void check_result(pkt_result_type got);
      pkt_result_type want;
      if (pending_results.size() == 0) begin
         $error("result: expected none, actual status %0d", got.status);
         failures++;
         return;
      end
      want = pending_results.pop_front();
      cmp_field("status", 32'(want.status), 32'(got.status));
      cmp_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
      cmp_field("out_last", 32'(want.out_last), 32'(got.out_last));
      cmp_field("queued_packets", 32'(want.queued), 32'(got.queued));
      cmp_field("received_total", want.received, got.received);
      cmp_field("sent_total", want.sent, got.sent);
      cmp_field("dropped_total", want.dropped, got.dropped);
   endfunction
endclass

module tb_packet_fifo_with_drop_counters;

   // timing
   localparam int unsigned CLK_HALF      = 5;
   localparam int unsigned RESET_CYCLES  = 11;
   localparam int unsigned MAX_GAP       = 10;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned TAIL_CYCLES   = 8;
   localparam int unsigned LONG_HOLD     = 300;
   localparam longint unsigned RUN_LIMIT_NS = 10_000_000;

   // design sizes
   localparam int unsigned QUEUE_DEPTH = 64;
   localparam int unsigned SLOT_BYTES  = 2048;
   localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH + 1);

   // register values of note
   localparam logic [CFG_W-1:0] LIMIT_ZERO     = '0;
   localparam logic [CFG_W-1:0] LIMIT_ALL_ONES = '1;
   localparam logic [CFG_W-1:0] LIMIT_SLOT     = 12'd2048;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_mode = MODE_PUSH;
   logic [7:0]       req_data_byte = '0;
   logic             req_byte_last = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [2:0]       rsp_status;
   logic [7:0]       rsp_out_byte;
   logic             rsp_out_last;
   logic [PTR_W-1:0] rsp_queued_packets;
   logic [CNT_W-1:0] rsp_received_total;
   logic [CNT_W-1:0] rsp_sent_total;
   logic [CNT_W-1:0] rsp_dropped_total;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_max_packet_len = MAX_LEN_RESET;

   packet_queue_checker queue_check = new();

   // traffic shaping shared by the sender and the receiver
   bit          req_steady = 1'b0;   // sender offers back to back
   bit          rsp_steady = 1'b0;   // receiver never stalls
   bit          req_offering = 1'b0; // tb copy of req_valid, updated at once
   int unsigned rsp_hold = 0;        // one long receiver stall, picked up by the sink
   int unsigned items_sent = 0;

   always #(CLK_HALF) clock = ~clock;

   packet_fifo_with_drop_counters #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .SLOT_BYTES  (SLOT_BYTES)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_data_byte      (req_data_byte),
      .req_byte_last      (req_byte_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_out_last       (rsp_out_last),
      .rsp_queued_packets (rsp_queued_packets),
      .rsp_received_total (rsp_received_total),
      .rsp_sent_total     (rsp_sent_total),
      .rsp_dropped_total  (rsp_dropped_total),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_packet_len (csr_max_packet_len)
   );

   // idle cycles before the next transfer on one side
   function automatic int unsigned draw_gap(bit steady);
      return steady ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // one input transfer; valid stays high afterwards so a zero gap gives back to back items
   task automatic send_item(input logic mode, input logic [7:0] data, input logic last);
      int unsigned gap;
      gap = draw_gap(req_steady);
      if (gap > 0) begin
         if (req_offering) begin
            req_valid <= 1'b0;
            req_offering = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_mode      <= mode;
      req_data_byte <= data;
      req_byte_last <= last;
      if (!req_offering) begin
         req_valid <= 1'b1;
         req_offering = 1'b1;
      end
      do @(posedge clock); while (req_stall !== 1'b0);
      queue_check.take_item(mode, data, last);
      items_sent++;
   endtask

   // sender goes quiet until every expected result has been transferred
   task automatic drain();
      if (req_offering) begin
         req_valid <= 1'b0;
         req_offering = 1'b0;
      end
      while (queue_check.pending() != 0) @(posedge clock);
   endtask

   // register write, only with the block idle
   task automatic write_limit(input logic [CFG_W-1:0] value);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid          <= 1'b1;
      csr_max_packet_len <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      queue_check.set_limit(value);
      csr_valid <= 1'b0;
   endtask

   // read items carry random ignored fields so every input bit toggles
   task automatic read_bytes(input int unsigned count);
      repeat (count)
         send_item(MODE_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   // one packet of random bytes, optionally with reads slipped in between its bytes
   task automatic push_packet(input int unsigned len, input bit interleave);
      for (int unsigned i = 0; i < len; i++) begin
         if (interleave && $urandom_range(0, 9) == 0)
            read_bytes(1);
         send_item(MODE_PUSH, 8'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   // mostly short packets, some right around a small limit, a few medium ones
   function automatic int unsigned pick_len();
      int unsigned r;
      int unsigned lim;
      int unsigned lo;
      lim = (32'(queue_check.max_len) < SLOT_BYTES) ? 32'(queue_check.max_len) : SLOT_BYTES;
      r   = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 6);
      if (r < 88 && lim <= 48) begin
         lo = (lim > 1) ? lim - 1 : 1;
         return $urandom_range(lo, lim + 1);
      end
      return $urandom_range(7, 40);
   endfunction

   // well-formed packets and read bursts, with some stray items and pauses
   task automatic random_phase(input int unsigned count);
      int unsigned stop;
      int unsigned r;
      stop = items_sent + count;
      req_steady = ($urandom_range(0, 3) == 0);
      rsp_steady = ($urandom_range(0, 3) == 0);
      while (items_sent < stop) begin
         r = $urandom_range(0, 99);
         if (r < 45)
            push_packet(pick_len(), 1'b1);
         else if (r < 83)
            read_bytes($urandom_range(1, 10));
         else if (r < 95)
            // stray item: may open a packet or end one early
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
         else if (r < 97)
            drain();
         else begin
            req_steady = !req_steady;
            rsp_steady = ($urandom_range(0, 1) == 0);
         end
      end
   endtask

   // fill every slot, then hit the full drop path from several angles and empty the queue
   task automatic fill_phase(input logic [CFG_W-1:0] limit);
      int unsigned len;
      write_limit(limit);
      req_steady = 1'b1;
      rsp_hold   = LONG_HOLD;
      while (queue_check.held < QUEUE_DEPTH) begin
         len = $urandom_range(1, 4);
         if (len > 32'(limit)) len = 32'(limit);
         push_packet(len, 1'b0);
      end
      req_steady = 1'b0;
      // dropped while full, multi-byte packets stay dropped to their last byte
      repeat ($urandom_range(2, 4)) push_packet($urandom_range(1, 5), 1'b0);
      // too long as well, but the full check wins
      push_packet(int'(limit) + 2, 1'b0);
      write_limit(LIMIT_ZERO);
      push_packet(2, 1'b0);
      write_limit(limit);
      // free one slot, take one packet, then full again
      while (queue_check.held == QUEUE_DEPTH) read_bytes(1);
      push_packet(1, 1'b0);
      push_packet(3, 1'b0);
      rsp_steady = ($urandom_range(0, 1) == 0);
      while (queue_check.held != 0) read_bytes(1);
      read_bytes(2);
   endtask

   // result side: random stalls, one long hold on request, check at each transfer
   initial begin : result_sink
      int unsigned    gap;
      pkt_result_type got;
      wait (reset === 1'b0);
      forever begin
         if (rsp_hold > 0) begin
            gap      = rsp_hold;
            rsp_hold = 0;
         end else begin
            gap = draw_gap(rsp_steady);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.status   = status_type'(rsp_status);
         got.out_byte = rsp_out_byte;
         got.out_last = rsp_out_last;
         got.queued   = rsp_queued_packets;
         got.received = rsp_received_total;
         got.sent     = rsp_sent_total;
         got.dropped  = rsp_dropped_total;
         queue_check.check_result(got);
      end
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset limit: empty read, single byte packet, two byte packet, read back
      read_bytes(1);
      send_item(MODE_PUSH, 8'hFF, 1'b1);
      send_item(MODE_PUSH, 8'h00, 1'b0);
      send_item(MODE_PUSH, 8'h5A, 1'b1);
      read_bytes(3);
      read_bytes(1);

      // zero limit: every packet is too long
      write_limit(LIMIT_ZERO);
      send_item(MODE_PUSH, 8'h12, 1'b1);
      send_item(MODE_PUSH, 8'hA5, 1'b0);
      send_item(MODE_PUSH, 8'h3C, 1'b1);

      // limit two: third byte trips the length check, two bytes fit
      write_limit(12'd2);
      send_item(MODE_PUSH, 8'h01, 1'b0);
      send_item(MODE_PUSH, 8'h80, 1'b0);
      send_item(MODE_PUSH, 8'h7F, 1'b1);
      send_item(MODE_PUSH, 8'hC3, 1'b0);
      send_item(MODE_PUSH, 8'h3C, 1'b1);

      // limit lowered mid-packet, then raised: the too-long mark sticks to its last byte
      send_item(MODE_PUSH, 8'h55, 1'b0);
      write_limit(12'd1);
      send_item(MODE_PUSH, 8'hAA, 1'b0);
      write_limit(LIMIT_ALL_ONES);
      send_item(MODE_PUSH, 8'h0F, 1'b1);
      send_item(MODE_PUSH, 8'hF0, 1'b1);
      read_bytes(4);

      // random traffic over a spread of limits, with back pressure and full queues
      write_limit(12'd16);
      random_phase(160);
      write_limit(LIMIT_ALL_ONES);
      rsp_hold = LONG_HOLD;
      random_phase(160);
      write_limit(12'd1);
      random_phase(120);
      fill_phase(12'd3);
      write_limit(LIMIT_SLOT);
      random_phase(120);
      write_limit(LIMIT_ZERO);
      random_phase(80);
      write_limit(CFG_W'($urandom_range(2, 40)));
      random_phase(160);
      fill_phase(CFG_W'($urandom_range(1, 8)));

      // all-ones limit: one long packet streamed back to back and read back in full
      write_limit(LIMIT_ALL_ONES);
      req_steady = 1'b1;
      rsp_steady = 1'b1;
      push_packet(100, 1'b0);
      read_bytes(101);

      write_limit(MAX_LEN_RESET);
      random_phase(160);

      // let the last results land and watch for strays
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (queue_check.failures == 0 && queue_check.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ sim.f @@
design/pfd_pkg.sv
design/pfd_ram.sv
design/packet_fifo_with_drop_counters.sv
sim/tb_packet_fifo_with_drop_counters.sv
